@@ src/tlg_pkg.sv @@
// Shared types and constants for the toroidal life generation engine.
// Used by the config, cell and core modules and by the checker; no dependencies.
package tlg_pkg;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int MASK_W     = 9;
	localparam int SIDE_W     = 7;
	localparam int SIDE_EFF_W = 9;
	localparam int GEN_W      = 32;
	localparam int POP_W      = 13;
	localparam int COORD_W    = 6;
	localparam int STEP_W     = 3;
	localparam int DIV_W      = 15;

	localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;
	localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;
	localparam logic [SIDE_W-1:0] SIDE_RST    = 7'd64;
	localparam logic [GEN_W-1:0]  START_RST   = 32'd0;

	localparam logic [STEP_W-1:0] MOD_FIRST_STEP = 3'(COORD_W - 1);

	typedef enum logic [1:0] {
		FUNC_CLEAR   = 2'd0,
		FUNC_SET     = 2'd1,
		FUNC_ADVANCE = 2'd2,
		FUNC_READ    = 2'd3
	} tlg_func_t;

	typedef enum logic [1:0] {
		REG_BIRTH   = 2'd0,
		REG_SURVIVE = 2'd1,
		REG_SIDE    = 2'd2,
		REG_START   = 2'd3
	} tlg_reg_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_MOD,
		ST_DISP,
		ST_CLR,
		ST_RD,
		ST_RMW,
		ST_A_UP,
		ST_A_CUR,
		ST_A_FIRST,
		ST_A_DN,
		ST_A_LOAD,
		ST_A_COL,
		ST_A_WR,
		ST_DONE
	} tlg_state_t;

	typedef struct packed {
		tlg_func_t          func;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} tlg_cmd_t;

	typedef struct packed {
		logic             cell_alive;
		logic [GEN_W-1:0] generation;
		logic [POP_W-1:0] population;
	} tlg_rsp_t;

	typedef struct packed {
		logic [MASK_W-1:0]     birth;
		logic [MASK_W-1:0]     survive;
		logic [SIDE_EFF_W-1:0] side;
		logic [GEN_W-1:0]      start_gen;
	} tlg_cfg_t;

endpackage

@@ src/tlg_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tlg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/tlg_cfg.sv @@
// APB register file: birth and survive masks, grid side, start generation.
// Depends on tlg_pkg; also derives the clamped grid side.
module tlg_cfg
	import tlg_pkg::*;
#(
	parameter int GRID_SIZE = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output tlg_cfg_t              cfg
);

	logic [MASK_W-1:0]     birth_q;
	logic [MASK_W-1:0]     survive_q;
	logic [SIDE_W-1:0]     side_q;
	logic [GEN_W-1:0]      start_q;
	logic [SIDE_EFF_W-1:0] side_ext;
	logic [SIDE_EFF_W-1:0] side_lim;
	tlg_reg_t              reg_sel;
	logic                  wr_en;

	assign pready   = 1'b1;
	assign reg_sel  = tlg_reg_t'(paddr[3:2]);
	assign wr_en    = psel && penable && pwrite;
	assign side_ext = SIDE_EFF_W'(side_q);
	assign side_lim = SIDE_EFF_W'(GRID_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q   <= BIRTH_RST;
			survive_q <= SURVIVE_RST;
			side_q    <= SIDE_RST;
			start_q   <= START_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_BIRTH:   birth_q   <= pwdata[MASK_W-1:0];
				REG_SURVIVE: survive_q <= pwdata[MASK_W-1:0];
				REG_SIDE:    side_q    <= pwdata[SIDE_W-1:0];
				REG_START:   start_q   <= pwdata[GEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_BIRTH:   prdata = CFG_DATA_W'(birth_q);
			REG_SURVIVE: prdata = CFG_DATA_W'(survive_q);
			REG_SIDE:    prdata = CFG_DATA_W'(side_q);
			REG_START:   prdata = CFG_DATA_W'(start_q);
			default:     prdata = '0;
		endcase
	end

	always_comb begin
		cfg.birth     = birth_q;
		cfg.survive   = survive_q;
		cfg.start_gen = start_q;
		if (side_q == '0) begin
			cfg.side = SIDE_EFF_W'(1);
		end else if (side_ext > side_lim) begin
			cfg.side = side_lim;
		end else begin
			cfg.side = side_ext;
		end
	end

endmodule

@@ src/tlg_cell.sv @@
// Next-state logic for one cell: wrapped neighbour count over three buffered
// rows and the birth/survive rule lookup. Depends on tlg_pkg.
module tlg_cell
	import tlg_pkg::*;
#(
	parameter int GRID_SIZE = 64
) (
	input  logic [GRID_SIZE-1:0]         up,
	input  logic [GRID_SIZE-1:0]         cur,
	input  logic [GRID_SIZE-1:0]         dn,
	input  logic [$clog2(GRID_SIZE)-1:0] col,
	input  logic [$clog2(GRID_SIZE)-1:0] last,
	input  logic [MASK_W-1:0]            birth,
	input  logic [MASK_W-1:0]            survive,
	output logic                         nxt
);

	localparam int IDXW = $clog2(GRID_SIZE);

	logic [IDXW-1:0] cl;
	logic [IDXW-1:0] cr;
	logic [3:0]      n;

	assign cl = (col == '0) ? last : IDXW'(col - 1'b1);
	assign cr = (col == last) ? '0 : IDXW'(col + 1'b1);

	assign n = 4'(up[cl]) + 4'(up[col]) + 4'(up[cr])
	         + 4'(cur[cl]) + 4'(cur[cr])
	         + 4'(dn[cl]) + 4'(dn[col]) + 4'(dn[cr]);

	assign nxt = cur[col] ? survive[n] : birth[n];

endmodule

@@ src/toroidal_life_generation_engine_core.sv @@
// Toroidal Life-like engine: one grid row per RAM word, one command at a time.
// Commands: read, set, clear and advance; advance walks the S-by-S grid of side S
// row by row, one cell per cycle through tlg_cell.
// Throughput: one command in flight; the next is taken once its result is queued.
// Reset: async; then a pass that clears every RAM row, with cmd_stall high.
module toroidal_life_generation_engine_core
	import tlg_pkg::*;
#(
	parameter int GRID_SIZE = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  tlg_cmd_t              cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output tlg_rsp_t              rsp
);

	localparam int              IDXW     = $clog2(GRID_SIZE);
	localparam logic [IDXW-1:0] LAST_ROW = IDXW'(GRID_SIZE - 1);

	tlg_cfg_t         cfg;
	tlg_state_t       state_q;
	tlg_state_t       state_d;

	logic             we;
	logic [IDXW-1:0]  waddr;
	logic [GRID_SIZE-1:0] wdata;
	logic [IDXW-1:0]  raddr;
	logic [GRID_SIZE-1:0] rdata;

	logic [IDXW-1:0]  row_q;
	logic [IDXW-1:0]  col_q;
	logic [STEP_W-1:0] step_q;
	logic             rsp_valid_q;
	logic [GEN_W-1:0] gen_q;
	logic [POP_W-1:0] live_q;

	tlg_func_t        func_q;
	logic [COORD_W-1:0] rem_r_q;
	logic [COORD_W-1:0] rem_c_q;
	logic             alive_q;
	logic [POP_W-1:0] pop_q;
	logic [GRID_SIZE-1:0] up_q;
	logic [GRID_SIZE-1:0] cur_q;
	logic [GRID_SIZE-1:0] dn_q;
	logic [GRID_SIZE-1:0] row0_q;
	logic [GRID_SIZE-1:0] new_row_q;
	tlg_rsp_t         rsp_q;

	logic [IDXW-1:0]  sm1;
	logic [IDXW-1:0]  r_idx;
	logic [IDXW-1:0]  c_idx;
	logic [DIV_W-1:0] div_sh;
	logic             full_side;
	logic             out_free;
	logic             nxt;
	logic [GRID_SIZE-1:0] bit_mask;

	assign sm1       = IDXW'(cfg.side - 1'b1);
	assign full_side = (cfg.side == SIDE_EFF_W'(GRID_SIZE));
	assign r_idx     = IDXW'(rem_r_q);
	assign c_idx     = IDXW'(rem_c_q);
	assign div_sh    = DIV_W'(cfg.side) << step_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign bit_mask  = {{(GRID_SIZE-1){1'b0}}, 1'b1} << c_idx;

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	tlg_cfg #(.GRID_SIZE(GRID_SIZE)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tlg_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_grid (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	tlg_cell #(.GRID_SIZE(GRID_SIZE)) u_cell (
		.up      (up_q),
		.cur     (cur_q),
		.dn      (dn_q),
		.col     (col_q),
		.last    (sm1),
		.birth   (cfg.birth),
		.survive (cfg.survive),
		.nxt     (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = row_q;
		wdata   = '0;
		raddr   = row_q;
		unique case (state_q) inside
			ST_INIT: begin
				we = 1'b1;
				if (row_q == LAST_ROW) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (step_q == '0) begin
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				unique case (func_q)
					FUNC_CLEAR:   state_d = ST_CLR;
					FUNC_ADVANCE: state_d = ST_A_UP;
					default:      state_d = ST_RD;
				endcase
			end
			ST_CLR: begin
				we = 1'b1;
				if (row_q == LAST_ROW) begin
					state_d = (func_q == FUNC_CLEAR) ? ST_DONE : ST_RD;
				end
			end
			ST_RD: begin
				raddr   = r_idx;
				state_d = ST_RMW;
			end
			ST_RMW: begin
				waddr = r_idx;
				wdata = rdata | bit_mask;
				we    = (func_q == FUNC_SET);
				state_d = ST_DONE;
			end
			ST_A_UP: begin
				raddr   = sm1;
				state_d = ST_A_CUR;
			end
			ST_A_CUR: begin
				raddr   = '0;
				state_d = ST_A_FIRST;
			end
			ST_A_FIRST, ST_A_DN: begin
				raddr   = IDXW'(row_q + 1'b1);
				state_d = ST_A_LOAD;
			end
			ST_A_LOAD: begin
				state_d = ST_A_COL;
			end
			ST_A_COL: begin
				if (col_q == sm1) begin
					state_d = ST_A_WR;
				end
			end
			ST_A_WR: begin
				we    = 1'b1;
				wdata = new_row_q;
				if (row_q == sm1) begin
					state_d = full_side ? ST_RD : ST_CLR;
				end else begin
					state_d = ST_A_DN;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
			gen_q       <= '0;
			live_q      <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q) inside
				ST_INIT, ST_CLR: begin
					row_q <= (row_q == LAST_ROW) ? '0 : IDXW'(row_q + 1'b1);
				end
				ST_IDLE: begin
					step_q <= MOD_FIRST_STEP;
				end
				ST_MOD: begin
					step_q <= STEP_W'(step_q - 1'b1);
				end
				ST_DISP: begin
					row_q <= '0;
					if (func_q == FUNC_CLEAR) begin
						live_q <= '0;
						gen_q  <= cfg.start_gen;
					end
				end
				ST_RMW: begin
					if (func_q == FUNC_SET && !rdata[c_idx]) begin
						live_q <= POP_W'(live_q + 1'b1);
					end
				end
				ST_A_LOAD: begin
					col_q <= '0;
				end
				ST_A_COL: begin
					col_q <= IDXW'(col_q + 1'b1);
				end
				ST_A_WR: begin
					if (row_q == sm1) begin
						live_q <= pop_q;
						gen_q  <= GEN_W'(gen_q + 1'b1);
						row_q  <= IDXW'(cfg.side);
					end else begin
						row_q <= IDXW'(row_q + 1'b1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q  <= cmd.func;
				rem_r_q <= cmd.row;
				rem_c_q <= cmd.col;
			end
			ST_MOD: begin
				if (DIV_W'(rem_r_q) >= div_sh) begin
					rem_r_q <= COORD_W'(rem_r_q - COORD_W'(div_sh));
				end
				if (DIV_W'(rem_c_q) >= div_sh) begin
					rem_c_q <= COORD_W'(rem_c_q - COORD_W'(div_sh));
				end
			end
			ST_DISP: begin
				pop_q   <= '0;
				alive_q <= 1'b0;
			end
			ST_RMW: begin
				alive_q <= (func_q == FUNC_SET) ? 1'b1 : rdata[c_idx];
			end
			ST_A_CUR: begin
				up_q <= rdata;
			end
			ST_A_FIRST: begin
				cur_q  <= rdata;
				row0_q <= rdata;
			end
			ST_A_LOAD: begin
				dn_q      <= (row_q == sm1) ? row0_q : rdata;
				new_row_q <= '0;
			end
			ST_A_COL: begin
				new_row_q[col_q] <= nxt;
				pop_q            <= POP_W'(pop_q + POP_W'(nxt));
			end
			ST_A_WR: begin
				up_q  <= cur_q;
				cur_q <= dn_q;
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_q.cell_alive <= alive_q;
					rsp_q.generation <= gen_q;
					rsp_q.population <= live_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/tlg_checker.sv @@
// Port-level checker for the toroidal life engine, bound to the top level.
// Depends on tlg_pkg; tracks the functions of outstanding commands.
module tlg_checker
	import tlg_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     cmd_valid,
	input logic     cmd_stall,
	input tlg_cmd_t cmd,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input tlg_rsp_t rsp
);

	logic       push;
	logic       pop;
	logic [1:0] cnt_q;
	tlg_func_t  f0_q;
	tlg_func_t  f1_q;

	assign push = cmd_valid && !cmd_stall;
	assign pop  = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			f0_q  <= FUNC_READ;
			f1_q  <= FUNC_READ;
		end else begin
			case ({push, pop})
				2'b10: begin
					if (cnt_q == '0) begin
						f0_q <= cmd.func;
					end else begin
						f1_q <= cmd.func;
					end
					cnt_q <= 2'(cnt_q + 1'b1);
				end
				2'b01: begin
					f0_q  <= f1_q;
					cnt_q <= 2'(cnt_q - 1'b1);
				end
				2'b11: begin
					if (cnt_q == 2'd1) begin
						f0_q <= cmd.func;
					end else begin
						f0_q <= f1_q;
						f1_q <= cmd.func;
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("stalled response changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> cmd_stall)
		else $error("command taken while previous one still in work");

	a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cnt_q != 2'd0)
		else $error("response without an outstanding command");

	a_clear_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		pop && f0_q == FUNC_CLEAR |-> !rsp.cell_alive && rsp.population == '0)
		else $error("clear left a live cell or nonzero population");

	a_set_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		pop && f0_q == FUNC_SET |-> rsp.cell_alive)
		else $error("set command answered with a dead cell");

endmodule

bind toroidal_life_generation_engine_core tlg_checker u_tlg_checker (.*);
